>>> hdl/crpe_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and arithmetic helpers for the catmull-rom path evaluator
// no dependencies

package crpe_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_W        = 24;
    localparam int NUM_COORD      = 6;
    localparam int DATA_W         = COORD_W * NUM_COORD;
    localparam int CNT_W          = 5;
    localparam int IDX_W          = 5;
    localparam int SLOT_W         = 4;
    localparam int T_W            = 18;
    localparam int U_W            = 17;
    localparam int H_W            = 32;
    localparam int P_W            = H_W + U_W + 1;
    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd10;
    localparam logic [U_W-1:0]   U_ONE       = 17'h10000;
    localparam logic signed [H_W-1:0] SAT_MAX = 32'sd8388607;
    localparam logic signed [H_W-1:0] SAT_MIN = -32'sd8388608;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef struct packed {
        logic               is_eval;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   i0;
        logic [IDX_W-1:0]   i1;
        logic [IDX_W-1:0]   i2;
        logic [IDX_W-1:0]   i3;
        logic [U_W-1:0]     u;
        logic [DATA_W-1:0]  data;
    } cmd_t;

    // q16 round half up: floor((x + 2^15) / 2^16)
    function automatic logic signed [H_W-1:0] rnd_q16(input logic signed [P_W-1:0] x);
        logic signed [P_W-1:0] y;
        y = x + P_W'(32768);
        return y[H_W+15:16];
    endfunction

    // floor((h + 1) / 2) saturated to q7.16
    function automatic logic [COORD_W-1:0] finish(input logic signed [H_W-1:0] h);
        logic signed [H_W-1:0] hp;
        logic signed [H_W-1:0] r;
        hp = h + H_W'(1);
        r  = hp >>> 1;
        if (r > SAT_MAX)
            return SAT_MAX[COORD_W-1:0];
        else if (r < SAT_MIN)
            return SAT_MIN[COORD_W-1:0];
        else
            return r[COORD_W-1:0];
    endfunction

endpackage

>>> hdl/crpe_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module crpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/crpe_front.sv
`timescale 1ns / 1ps
// front end: count register, input classification, t scaling and neighbor indices
// depends on crpe_pkg

module crpe_front #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [crpe_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [167:0]                  s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output crpe_pkg::cmd_t                q_cmd
);

    logic [crpe_pkg::CNT_W-1:0] count_reg;
    logic [crpe_pkg::CNT_W-1:0] n;
    logic [crpe_pkg::CNT_W-1:0] nm1;
    logic signed [crpe_pkg::T_W-1:0] t_in;
    logic [crpe_pkg::U_W-1:0] tc;
    logic [21:0] s;
    logic [5:0]  seg_raw;
    logic [crpe_pkg::IDX_W-1:0] seg;
    logic [crpe_pkg::IDX_W-1:0] seg2;
    logic [crpe_pkg::U_W-1:0] u;
    logic [crpe_pkg::SLOT_W-1:0] slot;
    logic keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= crpe_pkg::COUNT_RESET;
        else if (cfg_valid)
            count_reg <= cfg_data;
    end

    assign slot = s_tdata[3:0];
    assign t_in = $signed(s_tdata[165:148]);

    always_comb
    begin
        if (count_reg < crpe_pkg::CNT_W'(2))
            n = crpe_pkg::CNT_W'(2);
        else if (32'(count_reg) > MAX_POINTS)
            n = crpe_pkg::CNT_W'(MAX_POINTS);
        else
            n = count_reg;
        nm1 = n - crpe_pkg::CNT_W'(1);

        if (t_in[crpe_pkg::T_W-1])
            tc = '0;
        else if (t_in > $signed(crpe_pkg::T_W'(65536)))
            tc = crpe_pkg::U_ONE;
        else
            tc = t_in[crpe_pkg::U_W-1:0];

        s       = 22'(tc) * 22'(nm1);
        seg_raw = s[21:16];
        // last point maps to the end of the final segment
        if (seg_raw >= 6'(nm1))
        begin
            seg = n - crpe_pkg::IDX_W'(2);
            u   = crpe_pkg::U_ONE;
        end
        else
        begin
            seg = seg_raw[crpe_pkg::IDX_W-1:0];
            u   = {1'b0, s[15:0]};
        end
        seg2 = seg + crpe_pkg::IDX_W'(2);
    end

    always_comb
    begin
        q_cmd.is_eval = (s_tuser == crpe_pkg::MODE_EVAL);
        q_cmd.slot    = slot;
        q_cmd.i0      = (seg == '0) ? '0 : seg - crpe_pkg::IDX_W'(1);
        q_cmd.i1      = seg;
        q_cmd.i2      = seg + crpe_pkg::IDX_W'(1);
        q_cmd.i3      = (seg2 < n) ? seg2 : nm1;
        q_cmd.u       = u;
        q_cmd.data    = s_tdata[147:4];
    end

    // writes beyond the table are dropped here
    assign keep     = (s_tuser == crpe_pkg::MODE_EVAL) || (32'(slot) < MAX_POINTS);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule

>>> hdl/crpe_queue.sv
`timescale 1ns / 1ps
// two-entry command queue between front and back end
// no dependencies

module crpe_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         valid
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

endmodule

>>> hdl/crpe_back.sv
`timescale 1ns / 1ps
// back end: keypoint rams, coefficient stage and horner pipeline with output register
// depends on crpe_pkg and crpe_ram

module crpe_back #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  crpe_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crpe_pkg::DATA_W-1:0]     m_tdata
);

    localparam int AW = $clog2(MAX_POINTS);

    logic        en;
    logic        we;
    logic        re;
    logic [5:0]  v_reg;
    logic [crpe_pkg::U_W-1:0] u_reg [1:4];
    logic [AW-1:0] raddr [4];
    logic [crpe_pkg::DATA_W-1:0] rd [4];

    // whole pipeline holds while the output transaction is pending
    assign en      = !(v_reg[5] && !m_tready);
    assign cmd_pop = cmd_valid && en;
    assign we      = cmd_pop && !cmd.is_eval;
    assign re      = cmd_pop && cmd.is_eval;

    assign raddr[0] = AW'(cmd.i0);
    assign raddr[1] = AW'(cmd.i1);
    assign raddr[2] = AW'(cmd.i2);
    assign raddr[3] = AW'(cmd.i3);

    // one ram copy per neighbor so all four keypoints come out in the same cycle
    for (genvar j = 0; j < 4; j++)
    begin : g_ram
        crpe_ram #(
            .WIDTH (crpe_pkg::DATA_W),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (AW'(cmd.slot)),
            .wdata (cmd.data),
            .re    (re),
            .raddr (raddr[j]),
            .rdata (rd[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], re};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[1] <= cmd.u;
            u_reg[2] <= u_reg[1];
            u_reg[3] <= u_reg[2];
            u_reg[4] <= u_reg[3];
        end
    end

    for (genvar k = 0; k < crpe_pkg::NUM_COORD; k++)
    begin : g_lane
        logic signed [crpe_pkg::H_W-1:0] p0, p1, p2, p3;
        logic signed [crpe_pkg::H_W-1:0] a_next, b_next, c_next, d_next;
        logic signed [crpe_pkg::H_W-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
        logic signed [crpe_pkg::H_W-1:0] a3_reg, b3_reg, c3_reg;
        logic signed [crpe_pkg::H_W-1:0] a4_reg, b4_reg;
        logic signed [crpe_pkg::H_W-1:0] a5_reg;
        logic signed [crpe_pkg::P_W-1:0] m3_reg, m4_reg, m5_reg;
        logic signed [crpe_pkg::H_W-1:0] h1, h2, h3;
        logic [crpe_pkg::COORD_W-1:0]    out_reg;

        assign p0 = crpe_pkg::H_W'($signed(rd[0][k*crpe_pkg::COORD_W +: crpe_pkg::COORD_W]));
        assign p1 = crpe_pkg::H_W'($signed(rd[1][k*crpe_pkg::COORD_W +: crpe_pkg::COORD_W]));
        assign p2 = crpe_pkg::H_W'($signed(rd[2][k*crpe_pkg::COORD_W +: crpe_pkg::COORD_W]));
        assign p3 = crpe_pkg::H_W'($signed(rd[3][k*crpe_pkg::COORD_W +: crpe_pkg::COORD_W]));

        assign a_next = p1 <<< 1;
        assign b_next = p2 - p0;
        assign c_next = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
        assign d_next = ((p1 - p2) <<< 1) + (p1 - p2) - p0 + p3;

        assign h1 = c3_reg + crpe_pkg::rnd_q16(m3_reg);
        assign h2 = b4_reg + crpe_pkg::rnd_q16(m4_reg);
        assign h3 = a5_reg + crpe_pkg::rnd_q16(m5_reg);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a2_reg  <= a_next;
                b2_reg  <= b_next;
                c2_reg  <= c_next;
                d2_reg  <= d_next;
                m3_reg  <= d2_reg * $signed({1'b0, u_reg[2]});
                a3_reg  <= a2_reg;
                b3_reg  <= b2_reg;
                c3_reg  <= c2_reg;
                m4_reg  <= h1 * $signed({1'b0, u_reg[3]});
                a4_reg  <= a3_reg;
                b4_reg  <= b3_reg;
                m5_reg  <= h2 * $signed({1'b0, u_reg[4]});
                a5_reg  <= a4_reg;
                out_reg <= crpe_pkg::finish(h3);
            end
        end

        assign m_tdata[k*crpe_pkg::COORD_W +: crpe_pkg::COORD_W] = out_reg;
    end

    assign m_tvalid = v_reg[5];

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re))
        else $error("keypoint write and read in one cycle");

endmodule

>>> hdl/catmull_rom_path_evaluator.sv
`timescale 1ns / 1ps
// top level of the catmull-rom path evaluator
// depends on crpe_pkg, crpe_front, crpe_queue, crpe_back

// Takes one transaction per clock while s_tready is high. A mode 0 transaction
// stores a keypoint (position and target) and gives no result; a mode 1
// transaction evaluates the path at t_param and raises m_tvalid at the end of
// this path: it sits in the two-entry command queue until the back end pops it
// into the keypoint ram read (four ram copies give the four neighbors at once),
// then one stage for the spline coefficients, three multiplier stages of the
// horner chain, and the output register. Throughput is set by the horner
// pipeline, which takes a new evaluation every cycle; while a result waits on
// m_tready the whole back end holds, and once the queue is full s_tready drops.
// Keypoints must be written before they are evaluated. point_count is written
// through the cfg channel, which is always ready.

module catmull_rom_path_evaluator #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crpe_pkg::CNT_W-1:0]   cfg_data,    // point_count
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // point_index, pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, t_param, zero pad
    input  logic [167:0]                 s_tdata,
    input  logic                         s_tuser,     // mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_tgt_x, out_tgt_y, out_tgt_z
    output logic [crpe_pkg::DATA_W-1:0]  m_tdata
);

    localparam int CMD_W = $bits(crpe_pkg::cmd_t);

    crpe_pkg::cmd_t push_cmd;
    crpe_pkg::cmd_t pop_cmd;
    logic [CMD_W-1:0] pop_bits;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;

    crpe_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    crpe_queue #(
        .W (CMD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (pop_bits),
        .valid (q_valid)
    );

    assign pop_cmd = crpe_pkg::cmd_t'(pop_bits);

    crpe_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
